/* src/alu_dec_pkg.sv */
// ----------------------------------------------------------------------------
// ALU with opcode decode: shared types
// Transfer structures of the input and result channels and the operation
// codes produced by the opcode decoder.
// ----------------------------------------------------------------------------
package alu_dec_pkg;

  // Width of the operand and result fields on the ports.
  localparam int DATA_BITS = 16;

  // Basic operation chosen by the decoder.
  typedef enum logic [2:0] {
    OP_AND = 3'd0,
    OP_XOR = 3'd1,
    OP_OR  = 3'd2,
    OP_ADD = 3'd3,
    OP_SRL = 3'd4,
    OP_SLL = 3'd5,
    OP_SRA = 3'd6,
    OP_SLA = 3'd7
  } alu_op_t;

  // One input transfer.
  typedef struct packed {
    logic [4:0]           req_type;
    logic                 alu_enable;
    logic [DATA_BITS-1:0] operand_a;
    logic [DATA_BITS-1:0] operand_b;
  } alu_in_t;

  // One result transfer.
  typedef struct packed {
    logic [DATA_BITS-1:0] result;
    logic                 zero_flag;
    logic                 negative_flag;
    logic                 neg_or_zero_flag;
    logic                 nonzero_flag;
    logic                 carry_flag;
    logic                 overflow_flag;
  } alu_out_t;

endpackage

/* src/alu_with_opcode_decode_unit.sv */
// ----------------------------------------------------------------------------
// ALU with opcode decode
// Pipelined word ALU: opcode decode and operand preparation, main operation,
// optional decrement and result inversion, then flag generation.
// ----------------------------------------------------------------------------
//
//   channel  ports                       direction  transfer when
//   -------  --------------------------  ---------  ------------------------
//   input    start, busy, in_item        in         start high, busy low
//   result   out_valid, out_item         out        out_valid high (1 cycle)
//
// An item enters on every clock edge at which start is high and busy is low,
// so one item per cycle is sustained. Its result passes the four register
// stages in order (decode, main operation, decrement, flags) and is then
// held on out_item from the flags register, marked by out_valid. Each stage
// holds at most one word-wide adder.
// Reset is synchronous and active low; it clears the valid bits of every
// stage, and busy is high while reset is applied so that no transfer is
// taken then. The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module alu_with_opcode_decode_unit
  import alu_dec_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  alu_in_t  in_item,
  output logic     out_valid,
  output alu_out_t out_item
);

  // The datapath works at the width of the transfer fields.
  localparam int WORD_BITS = DATA_BITS;

  typedef logic [WORD_BITS-1:0] word_t;

  // Sum of two words with carry-in. Returns {overflow, carry out, sum}.
  // The carry into the top bit is recovered from the top sum bit.
  function automatic logic [WORD_BITS+1:0] add_word(input word_t x, input word_t y,
                                                    input logic cin);
    logic [WORD_BITS:0] full;
    logic               c_msb;
    begin
      full  = {1'b0, x} + {1'b0, y} + {{WORD_BITS{1'b0}}, cin};
      c_msb = full[WORD_BITS-1] ^ x[WORD_BITS-1] ^ y[WORD_BITS-1];
      add_word = {c_msb ^ full[WORD_BITS], full[WORD_BITS], full[WORD_BITS-1:0]};
    end
  endfunction

  // A transfer is refused only while reset is applied, since the synchronous
  // reset would otherwise drop the item from the first stage.
  assign busy = ~rst_n;

  logic accept;
  assign accept = start & ~busy;

  // --------------------------------------------------------------------------
  // Stage 1: opcode decode and operand preparation.
  // The opcode's bit 4 is the most significant decoder input, o0.
  // --------------------------------------------------------------------------
  logic    o0, o1, o2, o3, o4;
  logic    p0, p1, p2;
  logic    inv_a, inv_b, zero_b, ones_b, dec, inv_r, inc;
  alu_op_t op_dec;
  word_t   a_w, b_w, ta, tb;

  always_comb begin
    o0 = in_item.req_type[4];
    o1 = in_item.req_type[3];
    o2 = in_item.req_type[2];
    o3 = in_item.req_type[1];
    o4 = in_item.req_type[0];
    if (in_item.alu_enable) begin
      p0 = o0 & ~o1 & ~o2;
      p1 = (~o0 & ~o1 & ~o3 & o4) | (~o0 & ~o1 & o2 & ~o3) | (o1 & ~o2 & o3 & o4) |
           (o0 & o1 & ~o3) | (o0 & ~o2 & o4) | (o0 & o1 & ~o2);
      p2 = (~o0 & ~o1 & o2 & o3) | (o0 & ~o2 & o3 & ~o4) | (o0 & ~o2 & ~o3 & o4) |
           (o0 & o1 & ~o3) | (o0 & o1 & ~o2);
      inv_a  = ~o0 & o1 & ~o2 & ~o4;
      inv_b  = (o1 & ~o2 & o3 & o4) | (o0 & o1 & ~o2 & o4);
      zero_b = ~(o0 | o1 | o2 | o3 | o4) | (o0 & o1 & o2 & ~o3 & ~o4);
      dec    = (o0 & o1 & ~o2 & o3 & o4) | (o0 & o1 & o2 & ~o3 & o4);
      ones_b = (~o0 & o1 & ~o2 & ~o3) | (~o0 & ~o2 & ~o3 & o4);
      inv_r  = (~o0 & ~o1 & o2 & o4) | (~o0 & ~o1 & o3 & o4);
      inc    = (o0 & o1 & ~o2 & o3 & ~o4) | (o0 & o1 & o2 & ~o3 & ~o4);
    end else begin
      // With the decoder disabled the unit performs a plain addition.
      p0 = 1'b0;
      p1 = 1'b1;
      p2 = 1'b1;
      inv_a  = 1'b0;
      inv_b  = 1'b0;
      zero_b = 1'b0;
      dec    = 1'b0;
      ones_b = 1'b0;
      inv_r  = 1'b0;
      inc    = 1'b0;
    end
    op_dec = alu_op_t'({p0, p1, p2});

    a_w = word_t'(in_item.operand_a);
    b_w = word_t'(in_item.operand_b);
    ta  = inv_a ? ~a_w : a_w;

    // Operand b: inversion, then zeros, then ones, each overriding the last.
    // For a subtraction the two's complement of b replaces all of them.
    tb = inv_b ? ~b_w : b_w;
    if (zero_b) tb = '0;
    if (ones_b) tb = '1;
    if (inv_b && (op_dec == OP_ADD)) tb = word_t'(~b_w + word_t'(1));
  end

  logic    s1_valid_r;
  alu_op_t s1_op_r;
  word_t   s1_a_r, s1_b_r;
  logic    s1_inc_r, s1_dec_r, s1_inv_r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_op_r    <= op_dec;
    s1_a_r     <= ta;
    s1_b_r     <= tb;
    s1_inc_r   <= inc;
    s1_dec_r   <= dec;
    s1_inv_r_r <= inv_r;
  end

  // --------------------------------------------------------------------------
  // Stage 2: main operation with its carry and overflow.
  // --------------------------------------------------------------------------
  logic [WORD_BITS+1:0] s2_add;
  word_t                s2_word_nxt;
  logic                 s2_carry_nxt, s2_ovf_nxt;

  always_comb begin
    s2_add       = add_word(s1_a_r, s1_b_r, s1_inc_r);
    s2_word_nxt  = '0;
    s2_carry_nxt = 1'b0;
    s2_ovf_nxt   = 1'b0;
    unique case (s1_op_r)
      OP_AND: s2_word_nxt = s1_a_r & s1_b_r;
      OP_XOR: s2_word_nxt = s1_a_r ^ s1_b_r;
      OP_OR:  s2_word_nxt = s1_a_r | s1_b_r;
      OP_ADD: begin
        s2_word_nxt  = s2_add[WORD_BITS-1:0];
        s2_carry_nxt = s2_add[WORD_BITS];
        s2_ovf_nxt   = s2_add[WORD_BITS+1];
      end
      OP_SRL: s2_word_nxt = {1'b0, s1_a_r[WORD_BITS-1:1]};
      OP_SLL: begin
        s2_word_nxt  = {s1_a_r[WORD_BITS-2:0], 1'b0};
        s2_carry_nxt = s1_a_r[WORD_BITS-1];
      end
      OP_SRA: s2_word_nxt = {s1_a_r[WORD_BITS-1], s1_a_r[WORD_BITS-1:1]};
      OP_SLA: begin
        // Overflow when the sign changes, i.e. the two top bits differ.
        s2_word_nxt  = {s1_a_r[WORD_BITS-2:0], 1'b0};
        s2_carry_nxt = s1_a_r[WORD_BITS-1];
        s2_ovf_nxt   = s1_a_r[WORD_BITS-1] ^ s1_a_r[WORD_BITS-2];
      end
      default: s2_word_nxt = '0;
    endcase
  end

  logic  s2_valid_r;
  word_t s2_word_r;
  logic  s2_carry_r, s2_ovf_r, s2_dec_r, s2_inv_r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_word_r  <= s2_word_nxt;
    s2_carry_r <= s2_carry_nxt;
    s2_ovf_r   <= s2_ovf_nxt;
    s2_dec_r   <= s1_dec_r;
    s2_inv_r_r <= s1_inv_r_r;
  end

  // --------------------------------------------------------------------------
  // Stage 3: optional decrement (add all ones) and result inversion.
  // The decrement replaces the carry and accumulates the overflow.
  // --------------------------------------------------------------------------
  logic [WORD_BITS+1:0] s3_dec;
  word_t                s3_word_nxt;
  logic                 s3_carry_nxt, s3_ovf_nxt;

  always_comb begin
    s3_dec = add_word(s2_word_r, '1, 1'b0);
    if (s2_dec_r) begin
      s3_word_nxt  = s3_dec[WORD_BITS-1:0];
      s3_carry_nxt = s3_dec[WORD_BITS];
      s3_ovf_nxt   = s2_ovf_r | s3_dec[WORD_BITS+1];
    end else begin
      s3_word_nxt  = s2_word_r;
      s3_carry_nxt = s2_carry_r;
      s3_ovf_nxt   = s2_ovf_r;
    end
    if (s2_inv_r_r) s3_word_nxt = ~s3_word_nxt;
  end

  logic  s3_valid_r;
  word_t s3_word_r;
  logic  s3_carry_r, s3_ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_word_r  <= s3_word_nxt;
    s3_carry_r <= s3_carry_nxt;
    s3_ovf_r   <= s3_ovf_nxt;
  end

  // --------------------------------------------------------------------------
  // Stage 4: flags from the final word, into the output register. The zero
  // flag looks at the whole final word, the negative flag at its top bit.
  // --------------------------------------------------------------------------
  alu_out_t out_item_nxt;
  logic     zero_w, neg_w;

  always_comb begin
    zero_w = (s3_word_r == '0);
    neg_w  = s3_word_r[WORD_BITS-1];
    out_item_nxt.result           = DATA_BITS'(s3_word_r);
    out_item_nxt.zero_flag        = zero_w;
    out_item_nxt.negative_flag    = neg_w;
    out_item_nxt.neg_or_zero_flag = neg_w | zero_w;
    out_item_nxt.nonzero_flag     = ~zero_w;
    out_item_nxt.carry_flag       = s3_carry_r;
    out_item_nxt.overflow_flag    = s3_ovf_r;
  end

  logic     out_valid_r;
  alu_out_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTH
  // Every accepted transfer leaves as exactly one result, and every result
  // strobe matches an accepted transfer.
  a_latency: assert property (@(posedge clk)
    ($past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3)) |->
      (out_valid == $past(start && !busy, 4)))
    else $error("result strobe does not match an accepted transfer");

  // Logic operations and right shifts produce no carry and no overflow.
  a_logic_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && (s1_op_r == OP_AND || s1_op_r == OP_XOR || s1_op_r == OP_OR ||
                    s1_op_r == OP_SRL || s1_op_r == OP_SRA)) |=>
      (!s2_carry_r && !s2_ovf_r))
    else $error("carry or overflow raised by a logic or right-shift operation");

  // A decrement carries out exactly when its source word was nonzero.
  a_dec_carry: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && s2_dec_r) |=> (s3_carry_r == ($past(s2_word_r) != '0)))
    else $error("decrement carry inconsistent with its source word");
`endif

endmodule
